FILE: hdl/mest_pkg.sv
// shared constants, types and helper functions for the max energy symbol timing block
// no dependencies; used by mest_norm and max_energy_symbol_timing
`default_nettype none

package mest_pkg;

  localparam int MAX_OVERSAMPLING = 16;
  localparam int MAX_SYMBOLS      = 64;
  localparam int SAMPLE_BITS      = 16;

  localparam int ENERGY_BITS = 2 * SAMPLE_BITS + 4;
  localparam int STORE_DEPTH = MAX_OVERSAMPLING * MAX_SYMBOLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PHASE_W     = (MAX_OVERSAMPLING > 1) ? $clog2(MAX_OVERSAMPLING) : 1;
  localparam int OSR_W       = $clog2(MAX_OVERSAMPLING + 1);
  localparam int SYM_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int K_W         = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int TOT_W       = OSR_W + SYM_W;

  localparam int OUT_W        = 16;
  localparam int CHOSEN_W     = 4;
  localparam int OSR_FIELD_W  = 5;
  localparam int SYMS_FIELD_W = 7;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_OVERSAMPLING = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS      = 1'd1;

  localparam int OSR_RESET  = 4;
  localparam int SYMS_RESET = 16;

  // normalizer datapath widths
  localparam int FRAC_BITS = 26;
  localparam int MAG_W     = SAMPLE_BITS;
  localparam int SQ_W      = 2 * SAMPLE_BITS;
  localparam int MB_W      = (MAG_W > SYM_W) ? MAG_W : SYM_W;
  localparam int A_W       = SQ_W + SYM_W;
  localparam int NUM_W     = A_W + FRAC_BITS;
  localparam int D_W       = SYM_W + FRAC_BITS;
  localparam int SQ_IT     = (D_W + 1) / 2;
  localparam int OP_W      = (ENERGY_BITS > D_W) ? ENERGY_BITS + 1 : D_W + 1;
  localparam int SUB_W     = OP_W + 1;
  localparam int ITER_W    = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_SQ,
    CS_ACC,
    CS_SRD,
    CS_SCMP,
    CS_LD,
    CS_RD,
    CS_NORM
  } ctl_state_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_MUL1,
    NS_MUL2,
    NS_DIV,
    NS_SQRT,
    NS_RND
  } norm_state_t;

  typedef struct packed {
    logic             go;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } norm_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] value;
  } norm_rsp_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
    logic [MAG_W-1:0] m;
    m = v[SAMPLE_BITS-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mest_norm.sv
// sample normalizer: round(4096 * |s| * sqrt(n / e)) with sign and saturation
// one shared multiplier and one shared subtractor for bit-serial divide and square root
// depends on mest_pkg
`default_nettype none

module mest_norm (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mest_pkg::norm_req_t              req,
  input  wire logic [mest_pkg::ENERGY_BITS-1:0] energy,
  input  wire logic [mest_pkg::SYM_W-1:0]       nsym,
  output mest_pkg::norm_rsp_t                   rsp
);

  mest_pkg::norm_state_t state, state_next;

  logic                           neg;
  logic [mest_pkg::MAG_W-1:0]     mag;
  logic [mest_pkg::SQ_W-1:0]      prod;
  logic [mest_pkg::NUM_W-1:0]     num;
  logic [mest_pkg::ENERGY_BITS-1:0] rem;
  logic [mest_pkg::D_W-1:0]       quo;
  logic [mest_pkg::D_W-1:0]       v;
  logic [mest_pkg::D_W-1:0]       res;
  logic [mest_pkg::D_W-1:0]       sbit;
  logic [mest_pkg::ITER_W-1:0]    cnt;

  logic [mest_pkg::SQ_W-1:0]          mul_a;
  logic [mest_pkg::MB_W-1:0]          mul_b;
  logic [mest_pkg::SQ_W+mest_pkg::MB_W-1:0] mul_p;
  logic [mest_pkg::OP_W-1:0]          sub_a;
  logic [mest_pkg::OP_W-1:0]          sub_b;
  logic [mest_pkg::SUB_W-1:0]         diff;
  logic                               ge;
  logic [mest_pkg::ENERGY_BITS:0]     r_sh;
  logic [mest_pkg::D_W:0]             t_sum;
  logic [mest_pkg::D_W-1:0]           quo_shift;
  logic [mest_pkg::D_W:0]             rq;
  logic                               div_last;
  logic                               sqrt_last;

  localparam logic [mest_pkg::D_W:0] POS_LIM = (mest_pkg::D_W+1)'(2 ** (mest_pkg::OUT_W - 1) - 1);
  localparam logic [mest_pkg::D_W:0] NEG_LIM = (mest_pkg::D_W+1)'(2 ** (mest_pkg::OUT_W - 1));
  localparam logic [mest_pkg::D_W-1:0] SBIT_INIT =
    mest_pkg::D_W'(1) << (2 * (mest_pkg::SQ_IT - 1));

  assign mul_p     = (mest_pkg::SQ_W+mest_pkg::MB_W)'(mul_a)
                   * (mest_pkg::SQ_W+mest_pkg::MB_W)'(mul_b);
  assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge        = ~diff[mest_pkg::SUB_W-1];
  assign r_sh      = {rem, num[mest_pkg::NUM_W-1]};
  assign t_sum     = (mest_pkg::D_W+1)'(res) + (mest_pkg::D_W+1)'(sbit);
  assign quo_shift = {quo[mest_pkg::D_W-2:0], ge};
  assign rq        = ((mest_pkg::D_W+1)'(res) + 1'b1) >> 1;
  assign div_last  = (cnt == mest_pkg::ITER_W'(mest_pkg::NUM_W - 1));
  assign sqrt_last = (cnt == mest_pkg::ITER_W'(mest_pkg::SQ_IT - 1));

  always_comb begin
    state_next = state;
    case (state)
      mest_pkg::NS_IDLE: if (req.go) state_next = mest_pkg::NS_MUL1;
      mest_pkg::NS_MUL1: state_next = mest_pkg::NS_MUL2;
      mest_pkg::NS_MUL2: state_next = mest_pkg::NS_DIV;
      mest_pkg::NS_DIV:  if (div_last) state_next = mest_pkg::NS_SQRT;
      mest_pkg::NS_SQRT: if (sqrt_last) state_next = mest_pkg::NS_RND;
      mest_pkg::NS_RND:  state_next = mest_pkg::NS_IDLE;
      default:           state_next = mest_pkg::NS_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = mest_pkg::SQ_W'(mag);
    mul_b     = mest_pkg::MB_W'(mag);
    sub_a     = mest_pkg::OP_W'(r_sh);
    sub_b     = mest_pkg::OP_W'(energy);
    rsp.done  = 1'b0;
    rsp.value = '0;
    case (state)
      mest_pkg::NS_MUL2: begin
        mul_a = prod;
        mul_b = mest_pkg::MB_W'(nsym);
      end
      mest_pkg::NS_SQRT: begin
        sub_a = mest_pkg::OP_W'(v);
        sub_b = mest_pkg::OP_W'(t_sum);
      end
      mest_pkg::NS_RND: begin
        rsp.done = 1'b1;
        if (neg) begin
          if (rq > NEG_LIM) begin
            rsp.value = {1'b1, {(mest_pkg::OUT_W-1){1'b0}}};
          end else begin
            rsp.value = mest_pkg::OUT_W'((mest_pkg::D_W+1)'(0) - rq);
          end
        end else begin
          if (rq > POS_LIM) begin
            rsp.value = mest_pkg::OUT_W'(POS_LIM);
          end else begin
            rsp.value = mest_pkg::OUT_W'(rq);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mest_pkg::NS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mest_pkg::NS_IDLE: begin
        if (req.go) begin
          mag <= req.mag;
          neg <= req.neg;
        end
      end
      mest_pkg::NS_MUL1: begin
        prod <= mest_pkg::SQ_W'(mul_p);
      end
      mest_pkg::NS_MUL2: begin
        num <= {mest_pkg::A_W'(mul_p), {mest_pkg::FRAC_BITS{1'b0}}};
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      mest_pkg::NS_DIV: begin
        num <= num << 1;
        quo <= quo_shift;
        rem <= ge ? diff[mest_pkg::ENERGY_BITS-1:0] : r_sh[mest_pkg::ENERGY_BITS-1:0];
        if (div_last) begin
          v    <= quo_shift;
          res  <= '0;
          sbit <= SBIT_INIT;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      mest_pkg::NS_SQRT: begin
        if (ge) begin
          v   <= mest_pkg::D_W'(diff);
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("normalizer done held for more than one cycle");

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> (state == mest_pkg::NS_IDLE)) else $error("normalizer started while busy");

  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && !neg) |-> !rsp.value[mest_pkg::OUT_W-1])
    else $error("positive sample normalized to a negative value");

endmodule

`default_nettype wire

FILE: hdl/max_energy_symbol_timing.sv
// max energy symbol timing recovery: top level with sample store, energy table and sequencer
// depends on mest_pkg and mest_norm
`default_nettype none

// Samples enter one per start pulse while busy is low; each sample is accepted, then squared
// and accumulated into its phase energy with busy high. The sample that completes a
// block of oversampling * symbols_per_block starts the block-end sequence: a phase search
// over the phase energies, then for each symbol a store read and the normalizer (two
// multiply steps, 65 bit-serial divide steps and 17 square root steps on one shared
// subtractor, and a rounding step), or a store read alone when all energies are zero.
// Each result is shown for one cycle with strobe and cannot be held off. Configuration writes
// are taken only while busy is low and start is low, and clear the block in progress.
module max_energy_symbol_timing (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [mest_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                        strobe,
  output logic signed [mest_pkg::OUT_W-1:0]           symbol_value,
  output logic [mest_pkg::CHOSEN_W-1:0]               chosen_phase,
  output logic                                        zero_energy,
  output logic                                        last_of_block,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [mest_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [mest_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int MAX_OVS_BITS = mest_pkg::MAX_OVERSAMPLING;

  mest_pkg::ctl_state_t state, state_next;

  logic [mest_pkg::OSR_W-1:0]       osr;
  logic [mest_pkg::SYM_W-1:0]       nsym;
  logic [mest_pkg::PHASE_W-1:0]     phase_count;
  logic [mest_pkg::ADDR_W-1:0]      sample_count;
  logic [mest_pkg::SAMPLE_BITS-1:0] samp;
  logic [mest_pkg::SQ_W-1:0]        sq;
  logic [mest_pkg::ENERGY_BITS-1:0] e_rd;
  logic                             e_rd_vld;
  logic [MAX_OVS_BITS-1:0]          e_valid;
  logic [mest_pkg::ENERGY_BITS-1:0] energy_mem [mest_pkg::MAX_OVERSAMPLING];
  logic [mest_pkg::SAMPLE_BITS-1:0] sample_store [mest_pkg::STORE_DEPTH];
  logic [mest_pkg::SAMPLE_BITS-1:0] st_rd;
  logic [mest_pkg::PHASE_W-1:0]     idx;
  logic [mest_pkg::PHASE_W-1:0]     best;
  logic [mest_pkg::ENERGY_BITS-1:0] emax;
  logic [mest_pkg::K_W-1:0]         k;
  logic [mest_pkg::ADDR_W-1:0]      out_addr;

  logic                             accept;
  logic                             cfg_wr;
  logic                             in_search;
  logic [mest_pkg::PHASE_W-1:0]     e_addr;
  logic [mest_pkg::ENERGY_BITS-1:0] e_cur;
  logic [mest_pkg::ENERGY_BITS:0]   e_sum;
  logic [mest_pkg::ENERGY_BITS-1:0] e_new;
  logic [mest_pkg::TOT_W-1:0]       total;
  logic [mest_pkg::TOT_W-1:0]       cnt_plus;
  logic                             block_end;
  logic                             idx_last;
  logic                             upd;
  logic [mest_pkg::PHASE_W-1:0]     best_next;
  logic                             zero_blk;
  logic                             sym_last;
  logic                             emit;
  logic [mest_pkg::MAG_W-1:0]       samp_mag;
  logic [mest_pkg::OSR_FIELD_W-1:0]  osr_field;
  logic [mest_pkg::SYMS_FIELD_W-1:0] syms_field;
  logic [mest_pkg::OSR_W-1:0]       osr_eff;
  logic [mest_pkg::SYM_W-1:0]       syms_eff;

  mest_pkg::norm_req_t norm_req;
  mest_pkg::norm_rsp_t norm_rsp;

  mest_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .req    (norm_req),
    .energy (emax),
    .nsym   (nsym),
    .rsp    (norm_rsp)
  );

  assign samp_mag  = mest_pkg::mag_of(samp);
  assign e_cur     = e_rd_vld ? e_rd : '0;
  assign e_sum     = {1'b0, e_cur} + (mest_pkg::ENERGY_BITS+1)'(sq);
  assign e_new     = e_sum[mest_pkg::ENERGY_BITS] ? '1 : e_sum[mest_pkg::ENERGY_BITS-1:0];
  assign total     = mest_pkg::TOT_W'(osr) * mest_pkg::TOT_W'(nsym);
  assign cnt_plus  = mest_pkg::TOT_W'(sample_count) + 1'b1;
  assign block_end = (cnt_plus == total);
  assign idx_last  = (idx == mest_pkg::PHASE_W'(osr - 1'b1));
  assign upd       = (e_cur > emax);
  assign best_next = upd ? idx : best;
  assign zero_blk  = (emax == '0);
  assign sym_last  = ((mest_pkg::SYM_W'(k) + 1'b1) == nsym);

  // register writes saturate to the valid range
  assign osr_field  = cfg_data[mest_pkg::OSR_FIELD_W-1:0];
  assign syms_field = cfg_data[mest_pkg::SYMS_FIELD_W-1:0];
  always_comb begin
    if (osr_field == '0) begin
      osr_eff = mest_pkg::OSR_W'(1);
    end else if (mest_pkg::OSR_FIELD_W'(osr_field)
                 > mest_pkg::OSR_FIELD_W'(mest_pkg::MAX_OVERSAMPLING)) begin
      osr_eff = mest_pkg::OSR_W'(mest_pkg::MAX_OVERSAMPLING);
    end else begin
      osr_eff = mest_pkg::OSR_W'(osr_field);
    end
    if (syms_field == '0) begin
      syms_eff = mest_pkg::SYM_W'(1);
    end else if (syms_field > mest_pkg::SYMS_FIELD_W'(mest_pkg::MAX_SYMBOLS)) begin
      syms_eff = mest_pkg::SYM_W'(mest_pkg::MAX_SYMBOLS);
    end else begin
      syms_eff = mest_pkg::SYM_W'(syms_field);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mest_pkg::CS_IDLE: if (accept) state_next = mest_pkg::CS_SQ;
      mest_pkg::CS_SQ:   state_next = mest_pkg::CS_ACC;
      mest_pkg::CS_ACC:  state_next = block_end ? mest_pkg::CS_SRD : mest_pkg::CS_IDLE;
      mest_pkg::CS_SRD:  state_next = mest_pkg::CS_SCMP;
      mest_pkg::CS_SCMP: state_next = idx_last ? mest_pkg::CS_LD : mest_pkg::CS_SRD;
      mest_pkg::CS_LD:   state_next = mest_pkg::CS_RD;
      mest_pkg::CS_RD: begin
        if (zero_blk) begin
          state_next = sym_last ? mest_pkg::CS_IDLE : mest_pkg::CS_LD;
        end else begin
          state_next = mest_pkg::CS_NORM;
        end
      end
      mest_pkg::CS_NORM: begin
        if (norm_rsp.done) begin
          state_next = sym_last ? mest_pkg::CS_IDLE : mest_pkg::CS_LD;
        end
      end
      default: state_next = mest_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != mest_pkg::CS_IDLE);
    accept       = start && (state == mest_pkg::CS_IDLE);
    cfg_ready    = (state == mest_pkg::CS_IDLE) && !start;
    cfg_wr       = cfg_valid && cfg_ready;
    in_search    = (state == mest_pkg::CS_SRD) || (state == mest_pkg::CS_SCMP);
    e_addr       = in_search ? idx : phase_count;
    emit         = ((state == mest_pkg::CS_RD) && zero_blk)
                || ((state == mest_pkg::CS_NORM) && norm_rsp.done);
    norm_req.go  = (state == mest_pkg::CS_RD) && !zero_blk;
    norm_req.neg = st_rd[mest_pkg::SAMPLE_BITS-1];
    norm_req.mag = mest_pkg::mag_of(st_rd);
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_store[sample_count] <= sample;
    end
    st_rd <= sample_store[out_addr];
  end

  always_ff @(posedge clk) begin
    if (state == mest_pkg::CS_ACC) begin
      energy_mem[phase_count] <= e_new;
    end
    e_rd     <= energy_mem[e_addr];
    e_rd_vld <= e_valid[e_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mest_pkg::CS_IDLE;
      osr          <= mest_pkg::OSR_W'(mest_pkg::OSR_RESET);
      nsym         <= mest_pkg::SYM_W'(mest_pkg::SYMS_RESET);
      phase_count  <= '0;
      sample_count <= '0;
      e_valid      <= '0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (cfg_wr) begin
        case (cfg_index)
          mest_pkg::REG_OVERSAMPLING: osr  <= osr_eff;
          mest_pkg::REG_SYMBOLS:      nsym <= syms_eff;
          default: begin
          end
        endcase
        phase_count  <= '0;
        sample_count <= '0;
        e_valid      <= '0;
      end
      if (state == mest_pkg::CS_ACC) begin
        e_valid[phase_count] <= 1'b1;
        if (block_end) begin
          phase_count  <= '0;
          sample_count <= '0;
        end else begin
          sample_count <= sample_count + 1'b1;
          if ((mest_pkg::OSR_W'(phase_count) + 1'b1) >= osr) begin
            phase_count <= '0;
          end else begin
            phase_count <= phase_count + 1'b1;
          end
        end
      end
      if (emit && sym_last) begin
        e_valid <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      samp <= sample;
    end
    if (state == mest_pkg::CS_SQ) begin
      sq <= mest_pkg::SQ_W'(samp_mag) * mest_pkg::SQ_W'(samp_mag);
    end
    if ((state == mest_pkg::CS_ACC) && block_end) begin
      idx  <= '0;
      best <= '0;
      emax <= '0;
    end
    if (state == mest_pkg::CS_SCMP) begin
      idx  <= idx + 1'b1;
      best <= best_next;
      if (upd) begin
        emax <= e_cur;
      end
      if (idx_last) begin
        out_addr <= mest_pkg::ADDR_W'(best_next);
        k        <= '0;
      end
    end
    if (emit) begin
      symbol_value  <= zero_blk ? '0 : norm_rsp.value;
      chosen_phase  <= mest_pkg::CHOSEN_W'(best);
      zero_energy   <= zero_blk;
      last_of_block <= sym_last;
      out_addr      <= out_addr + mest_pkg::ADDR_W'(osr);
      k             <= k + 1'b1;
    end
  end

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("item emitted without a block in progress");

  a_mid_block_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_block) |-> busy) else $error("idle before the last item of a block");

  a_zero_output: assert property (@(posedge clk) disable iff (rst)
    (strobe && zero_energy) |-> (symbol_value == '0 && chosen_phase == '0))
    else $error("zero energy block with nonzero item");

  a_no_accept_midblock_out: assert property (@(posedge clk) disable iff (rst)
    (state == mest_pkg::CS_NORM) |-> !cfg_ready) else $error("config open during output");

endmodule

`default_nettype wire

FILE: tb/sv/mest_symbol_checker.sv
// checker for max_energy_symbol_timing: follows register writes and accepted samples,
// predicts each emitted symbol and compares it field by field with the block's output
// depends on mest_pkg
`timescale 1ns / 100ps

module mest_symbol_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   busy,
  input  wire logic signed [mest_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                   strobe,
  input  wire logic signed [mest_pkg::OUT_W-1:0]      symbol_value,
  input  wire logic [mest_pkg::CHOSEN_W-1:0]          chosen_phase,
  input  wire logic                                   zero_energy,
  input  wire logic                                   last_of_block,
  input  wire logic                                   cfg_valid,
  input  wire logic                                   cfg_ready,
  input  wire logic [mest_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [mest_pkg::CFG_DATA_W-1:0]        cfg_data,
  output int                                          fail_count,
  output int                                          pending,
  output int                                          symbols_seen,
  output int                                          blank_blocks,
  output int                                          phases,
  output int                                          block_len
);

  localparam longint unsigned ENERGY_LIMIT = (64'd1 << mest_pkg::ENERGY_BITS) - 64'd1;
  localparam int SCALE_BITS = 26;

  typedef struct packed {
    logic signed [mest_pkg::OUT_W-1:0] value;
    logic [mest_pkg::CHOSEN_W-1:0]     phase;
    logic                              blank;
    logic                              last;
  } symbol_t;

  logic [mest_pkg::OSR_FIELD_W-1:0]        osr_reg;
  logic [mest_pkg::SYMS_FIELD_W-1:0]       syms_reg;
  logic signed [mest_pkg::SAMPLE_BITS-1:0] history [0:mest_pkg::STORE_DEPTH-1];
  longint unsigned                         phase_sum [0:mest_pkg::MAX_OVERSAMPLING-1];
  int unsigned                             taken;
  int unsigned                             next_phase;
  symbol_t                                 symbols_due[$];

  function automatic int unsigned effective(input int unsigned raw, input int unsigned ceiling);
    if (raw == 0) return 1;
    if (raw > ceiling) return ceiling;
    return raw;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // sample over block rms, rounded half away from zero, saturated to q4.12
  function automatic logic signed [mest_pkg::OUT_W-1:0] scale_symbol(
      input logic signed [mest_pkg::SAMPLE_BITS-1:0] s, input longint unsigned e,
      input int unsigned n);
    longint signed wide;
    longint unsigned mag;
    longint unsigned ratio;
    longint unsigned q;
    logic [mest_pkg::OUT_W-1:0] r;
    wide = s;
    mag = (wide < 0) ? -wide : wide;
    ratio = ((mag * mag * n) << SCALE_BITS) / e;
    q = (int_sqrt(ratio) + 1) >> 1;
    if (wide < 0) begin
      if (q > 32768) q = 32768;
      r = mest_pkg::OUT_W'(-q);
    end else begin
      if (q > 32767) q = 32767;
      r = mest_pkg::OUT_W'(q);
    end
    return r;
  endfunction

  task automatic restart();
    int p;
    for (p = 0; p < mest_pkg::MAX_OVERSAMPLING; p++) phase_sum[p] = 0;
    taken = 0;
    next_phase = 0;
  endtask

  task automatic absorb(input logic signed [mest_pkg::SAMPLE_BITS-1:0] s);
    longint signed wide;
    longint unsigned sq;
    longint unsigned total;
    longint unsigned peak;
    int unsigned osr;
    int unsigned n;
    int unsigned best;
    int unsigned p;
    int unsigned k;
    symbol_t due;
    osr = effective(osr_reg, mest_pkg::MAX_OVERSAMPLING);
    n = effective(syms_reg, mest_pkg::MAX_SYMBOLS);
    history[taken] = s;
    wide = s;
    sq = (wide < 0) ? -wide : wide;
    sq = sq * sq;
    total = phase_sum[next_phase] + sq;
    phase_sum[next_phase] = (total > ENERGY_LIMIT) ? ENERGY_LIMIT : total;
    next_phase++;
    if (next_phase >= osr) next_phase = 0;
    taken++;
    if (taken < osr * n) return;
    best = 0;
    peak = 0;
    for (p = 0; p < osr; p++) begin
      if (phase_sum[p] > peak) begin
        peak = phase_sum[p];
        best = p;
      end
    end
    for (k = 0; k < n; k++) begin
      due.value = (peak == 0) ? '0 : scale_symbol(history[k * osr + best], peak, n);
      due.phase = mest_pkg::CHOSEN_W'(best);
      due.blank = (peak == 0);
      due.last = (k + 1 == n);
      symbols_due.push_back(due);
    end
    if (peak == 0) blank_blocks++;
    restart();
  endtask

  task automatic diff(input string field, input logic signed [31:0] want,
                      input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_symbol();
    symbol_t due;
    symbols_seen++;
    if (symbols_due.size() == 0) begin
      $display("%0t: symbol_value expected none got %0d", $time, symbol_value);
      fail_count++;
      return;
    end
    due = symbols_due.pop_front();
    diff("symbol_value", due.value, symbol_value);
    diff("chosen_phase", due.phase, chosen_phase);
    diff("zero_energy", due.blank, zero_energy);
    diff("last_of_block", due.last, last_of_block);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      osr_reg = mest_pkg::OSR_RESET;
      syms_reg = mest_pkg::SYMS_RESET;
      restart();
      symbols_due.delete();
    end else begin
      if (strobe) check_symbol();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mest_pkg::REG_OVERSAMPLING) begin
          osr_reg = cfg_data[mest_pkg::OSR_FIELD_W-1:0];
        end else if (cfg_index == mest_pkg::REG_SYMBOLS) begin
          syms_reg = cfg_data[mest_pkg::SYMS_FIELD_W-1:0];
        end
        restart();
      end
      if (start && !busy) absorb(sample);
    end
    pending = symbols_due.size();
    phases = effective(osr_reg, mest_pkg::MAX_OVERSAMPLING);
    block_len = phases * effective(syms_reg, mest_pkg::MAX_SYMBOLS);
  end

endmodule

FILE: tb/sv/tb_max_energy_symbol_timing.sv
// testbench top for max_energy_symbol_timing: drives samples and register writes in bursts
// and reports the verdict; prediction and comparison live in mest_symbol_checker
// depends on mest_pkg, mest_symbol_checker and the block itself
`timescale 1ns / 100ps

module tb_max_energy_symbol_timing;

  typedef enum int {
    FILL_WIDE,
    FILL_QUIET,
    FILL_ALIGNED,
    FILL_SPIKES,
    FILL_BLANK,
    FILL_FLOOR,
    FILL_ANY
  } fill_t;

  logic                                    clk;
  logic                                    rst;
  logic                                    start;
  logic                                    busy;
  logic signed [mest_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    strobe;
  logic signed [mest_pkg::OUT_W-1:0]       symbol_value;
  logic [mest_pkg::CHOSEN_W-1:0]           chosen_phase;
  logic                                    zero_energy;
  logic                                    last_of_block;
  logic                                    cfg_valid;
  logic                                    cfg_ready;
  logic [mest_pkg::CFG_INDEX_W-1:0]        cfg_index;
  logic [mest_pkg::CFG_DATA_W-1:0]         cfg_data;

  int fail_count;
  int pending;
  int symbols_seen;
  int blank_blocks;
  int phases;
  int block_len;
  int sent;
  int writes;
  int burst_left;
  bit steady;

  // extremes, an all-zero block, a tie between phases, then a block cut short
  logic signed [mest_pkg::SAMPLE_BITS-1:0] opening [0:13] = '{
    16'sh7fff, 16'sh8000, -16'sd1, 16'sd1,
    16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd300, -16'sd300, -16'sd300, 16'sd300,
    16'sd5, 16'sd7
  };
  // single-symbol blocks
  logic signed [mest_pkg::SAMPLE_BITS-1:0] singles [0:4] = '{
    16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1
  };

  max_energy_symbol_timing dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample        (sample),
    .strobe        (strobe),
    .symbol_value  (symbol_value),
    .chosen_phase  (chosen_phase),
    .zero_energy   (zero_energy),
    .last_of_block (last_of_block),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mest_symbol_checker symbol_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample        (sample),
    .strobe        (strobe),
    .symbol_value  (symbol_value),
    .chosen_phase  (chosen_phase),
    .zero_energy   (zero_energy),
    .last_of_block (last_of_block),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .symbols_seen  (symbols_seen),
    .blank_blocks  (blank_blocks),
    .phases        (phases),
    .block_len     (block_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [mest_pkg::SAMPLE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if ($urandom_range(0, 39) == 0) drain();
    burst_left--;
    start <= 1'b1;
    sample <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [mest_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mest_pkg::CFG_DATA_W-1:0] data);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    writes++;
  endtask

  function automatic logic signed [mest_pkg::SAMPLE_BITS-1:0] make_sample(
      input fill_t fill, input int idx, input int osr, input int mark);
    logic signed [mest_pkg::SAMPLE_BITS-1:0] quiet;
    quiet = 16'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) quiet = -quiet;
    case (fill)
      FILL_WIDE:    return 16'($urandom);
      FILL_QUIET:   return quiet;
      FILL_ALIGNED: return (idx % osr == mark) ? 16'($urandom) : quiet;
      FILL_SPIKES:  return (idx != mark) ? 16'sd0 :
                           ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
      FILL_FLOOR:   return 16'sh8000;
      default:      return 16'sd0;
    endcase
  endfunction

  task automatic run_phase(input logic [mest_pkg::CFG_DATA_W-1:0] osr_raw,
                           input logic [mest_pkg::CFG_DATA_W-1:0] syms_raw,
                           input int blocks, input int loose, input fill_t fill);
    int osr;
    int len;
    int mark;
    int b;
    int i;
    fill_t kind;
    write_reg(mest_pkg::REG_OVERSAMPLING, osr_raw);
    write_reg(mest_pkg::REG_SYMBOLS, syms_raw);
    @(negedge clk);
    osr = phases;
    len = block_len;
    @(posedge clk);
    steady = ($urandom_range(0, 3) == 0);
    for (b = 0; b < blocks; b++) begin
      kind = (fill == FILL_ANY) ? fill_t'($urandom_range(FILL_WIDE, FILL_BLANK)) : fill;
      mark = (kind == FILL_SPIKES) ? $urandom_range(0, len - 1) : $urandom_range(0, osr - 1);
      for (i = 0; i < len; i++) send_sample(make_sample(kind, i, osr, mark));
    end
    // partial block, dropped by the next register write
    for (i = 0; i < loose; i++) send_sample(make_sample(FILL_WIDE, i, osr, 0));
  endtask

  initial begin
    int i;
    rst <= 1'b1;
    start <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mest_pkg::REG_OVERSAMPLING;
    cfg_data <= '0;
    burst_left = 0;
    steady = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(mest_pkg::REG_OVERSAMPLING, 7'd2);
    write_reg(mest_pkg::REG_SYMBOLS, 7'd2);
    for (i = 0; i < 12; i++) send_sample(opening[i]);
    drain();
    for (i = 12; i < 14; i++) send_sample(opening[i]);
    write_reg(mest_pkg::REG_OVERSAMPLING, 7'd1);
    write_reg(mest_pkg::REG_SYMBOLS, 7'd1);
    for (i = 0; i < 5; i++) send_sample(singles[i]);

    run_phase(7'd4, 7'd3, 2, 5, FILL_ANY);
    run_phase(7'd16, 7'd2, 1, 3, FILL_ANY);
    run_phase(7'd1, 7'd127, 1, 0, FILL_FLOOR);
    run_phase(7'h7f, 7'd1, 2, 2, FILL_ANY);
    run_phase(7'd0, 7'd0, 10, 0, FILL_ANY);
    run_phase(7'h63, 7'd5, 1, 2, FILL_ALIGNED);
    run_phase(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)), 2, 1, FILL_ANY);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
    $display("drove %0d samples across %0d register writes", sent, writes);
    $display("checked %0d symbols, %0d blocks with no energy", symbols_seen, blank_blocks);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
